### sv/qcl_pkg.sv
// Shared types and constants for the quota credit ledger.
// No dependencies; imported by qcl_ctrl, qcl_datapath and quota_credit_ledger.
package qcl_pkg;

	// configuration port geometry
	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned MASK_W     = 4;
	localparam int unsigned LIMIT_W    = 32;
	localparam int unsigned MAX_CLASSES = 4;

	// payload field widths
	localparam int unsigned ACTION_W = 2;
	localparam int unsigned RES_W    = 2;
	localparam int unsigned AMT_IN_W = 32;
	localparam int unsigned OUT_W    = 32;

	// register indexes
	localparam logic [CFG_ADDR_W-1:0] CFG_MASK   = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_LIMIT0 = 3'd1;

	// request actions
	typedef enum logic [ACTION_W-1:0] {
		ACT_CHECK   = 2'd0,
		ACT_TRY     = 2'd1,
		ACT_FORCE   = 2'd2,
		ACT_RELEASE = 2'd3
	} action_t;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_COMMIT
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic eval;
		logic commit;
	} cmd_t;

endpackage

### sv/quota_credit_ledger.sv
// Quota credit ledger top level: per-class used counters checked against limits.
// Each input beat passes the registered capture, evaluate and commit steps before its result beat.
// The controller takes no new request until the capture/evaluate/commit sequence of the
// last one is done; a pending result beat also holds off a new input beat.
// Reset (arst_n low, asynchronous): mask, limits and all used counters clear to zero.
// Depends on qcl_pkg, qcl_ctrl and qcl_datapath.
module quota_credit_ledger #(
	parameter int unsigned NUM_RESOURCES = 4,
	parameter int unsigned AMOUNT_WIDTH  = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [qcl_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [qcl_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [qcl_pkg::ACTION_W-1:0]   action,
	input  logic [qcl_pkg::RES_W-1:0]      resource,
	input  logic [qcl_pkg::AMT_IN_W-1:0]   amount,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           accepted,
	output logic                           tracked,
	output logic [qcl_pkg::OUT_W-1:0]      used_now,
	output logic [qcl_pkg::OUT_W-1:0]      headroom
);
	import qcl_pkg::*;

	cmd_t cmd;

	// sequencer
	qcl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// counters and arithmetic
	qcl_datapath #(
		.NUM_RESOURCES (NUM_RESOURCES),
		.AMOUNT_WIDTH  (AMOUNT_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.action    (action),
		.resource  (resource),
		.amount    (amount),
		.accepted  (accepted),
		.tracked   (tracked),
		.used_now  (used_now),
		.headroom  (headroom)
	);

endmodule

### sv/qcl_ctrl.sv
// Sequencer for the ledger: capture, evaluate, commit, plus output beat valid.
// Depends on qcl_pkg for state_t and cmd_t.
module qcl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output qcl_pkg::cmd_t cmd
);
	import qcl_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (in_valid && in_ready) state_d = S_EVAL;
			S_EVAL:   state_d = S_COMMIT;
			S_COMMIT: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// outputs: take a new beat only once the result slot is free or draining
	always_comb begin
		in_ready    = (state_q == S_IDLE) && (!out_valid_q || out_ready);
		cmd.capture = in_valid && in_ready;
		cmd.eval    = (state_q == S_EVAL);
		cmd.commit  = (state_q == S_COMMIT);
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### sv/qcl_datapath.sv
// Ledger datapath: config registers, per-class used counters, fit and update math.
// Depends on qcl_pkg for widths, register indexes, actions and cmd_t.
module qcl_datapath #(
	parameter int unsigned NUM_RESOURCES = 4,
	parameter int unsigned AMOUNT_WIDTH  = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  qcl_pkg::cmd_t                      cmd,
	input  logic                               cfg_we,
	input  logic [qcl_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [qcl_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic [qcl_pkg::ACTION_W-1:0]       action,
	input  logic [qcl_pkg::RES_W-1:0]          resource,
	input  logic [qcl_pkg::AMT_IN_W-1:0]       amount,
	output logic                               accepted,
	output logic                               tracked,
	output logic [qcl_pkg::OUT_W-1:0]          used_now,
	output logic [qcl_pkg::OUT_W-1:0]          headroom
);
	import qcl_pkg::*;

	// classes that have a limit register
	localparam int unsigned NR = (NUM_RESOURCES < MAX_CLASSES) ? NUM_RESOURCES : MAX_CLASSES;
	localparam int unsigned IW = (NR > 1) ? $clog2(NR) : 1;
	localparam int unsigned AW = AMOUNT_WIDTH;
	// working width for mixed limit / counter compares
	localparam int unsigned CW = (AW > LIMIT_W) ? AW : LIMIT_W;

	logic [MASK_W-1:0]  mask_q;
	logic [LIMIT_W-1:0] lim_q [NR];
	logic [AW-1:0]      cnt_q [NR];

	// stage 1: captured request and its class state
	action_t            act_s1;
	logic [IW-1:0]      idx_s1;
	logic               trk_s1;
	logic [AW-1:0]      amt_s1;
	logic [LIMIT_W-1:0] lim_s1;
	logic [AW-1:0]      cur_s1;

	// stage 2: decided update
	logic               trk_s2;
	logic               acc_s2;
	logic [LIMIT_W-1:0] lim_s2;
	logic [AW-1:0]      new_s2;

	// request decode
	logic          req_trk;
	logic [IW-1:0] req_idx;
	logic [CW-1:0] amt_ext;

	assign req_idx = IW'(resource);
	assign req_trk = ({1'b0, resource} < (RES_W+1)'(NR)) && mask_q[resource];
	assign amt_ext = CW'(amount);

	// evaluation math
	logic [CW-1:0] lim_w, cur_w, amt_w, room;
	logic          fits;
	logic [AW:0]   sum;
	logic [AW-1:0] add_sat, sub_flr, new_d;
	logic          acc_d;

	always_comb begin
		lim_w   = CW'(lim_s1);
		cur_w   = CW'(cur_s1);
		amt_w   = CW'(amt_s1);
		room    = (lim_w > cur_w) ? (lim_w - cur_w) : '0;
		fits    = (amt_w <= room);
		sum     = {1'b0, cur_s1} + {1'b0, amt_s1};
		add_sat = sum[AW] ? '1 : sum[AW-1:0];
		sub_flr = (amt_s1 >= cur_s1) ? '0 : (cur_s1 - amt_s1);
		new_d   = cur_s1;
		acc_d   = 1'b1;
		case (act_s1)
			ACT_CHECK: acc_d = fits;
			ACT_TRY: begin
				acc_d = fits;
				if (fits) new_d = add_sat;
			end
			ACT_FORCE:   new_d = add_sat;
			ACT_RELEASE: new_d = sub_flr;
			default:     new_d = cur_s1;
		endcase
		if (!trk_s1) acc_d = 1'b1;
	end

	// headroom after the update
	logic [CW-1:0] lim2_w, new_w, head_w;

	always_comb begin
		lim2_w = CW'(lim_s2);
		new_w  = CW'(new_s2);
		head_w = (lim2_w > new_w) ? (lim2_w - new_w) : '0;
	end

	// config registers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			for (int r = 0; r < NR; r++) begin
				lim_q[r] <= '0;
				cnt_q[r] <= '0;
			end
		end else begin
			if (cfg_we && (cfg_addr == CFG_MASK)) begin
				mask_q <= cfg_wdata[MASK_W-1:0];
			end
			for (int r = 0; r < NR; r++) begin
				if (cfg_we && (cfg_addr == CFG_LIMIT0 + CFG_ADDR_W'(r))) begin
					lim_q[r] <= cfg_wdata[LIMIT_W-1:0];
					cnt_q[r] <= '0;
				end
			end
			if (cmd.commit && trk_s2) begin
				cnt_q[idx_s1] <= new_s2;
			end
		end
	end

	// capture, evaluate and result registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_s1 <= action_t'(action);
			idx_s1 <= req_idx;
			trk_s1 <= req_trk;
			amt_s1 <= amt_ext[AW-1:0];
			lim_s1 <= req_trk ? lim_q[req_idx] : '0;
			cur_s1 <= req_trk ? cnt_q[req_idx] : '0;
		end
		if (cmd.eval) begin
			trk_s2 <= trk_s1;
			acc_s2 <= acc_d;
			lim_s2 <= lim_s1;
			new_s2 <= new_d;
		end
		if (cmd.commit) begin
			accepted <= acc_s2;
			tracked  <= trk_s2;
			used_now <= trk_s2 ? new_w[OUT_W-1:0] : '0;
			headroom <= trk_s2 ? head_w[OUT_W-1:0] : '0;
		end
	end

endmodule
